// File: hdl/ordered_unique_byte_list_top_assert.svh
// ---------------------------------------------------------------------------
// ordered unique byte list assertion macros
// Clocked assertion wrappers for the checker file of this block.
// ---------------------------------------------------------------------------
`ifndef ORDERED_UNIQUE_BYTE_LIST_TOP_ASSERT_SVH
`define ORDERED_UNIQUE_BYTE_LIST_TOP_ASSERT_SVH

// property checked on every rising edge outside of reset
`define OUBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising edge, reset included
`define OUBL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/oubl_pkg.sv
// ---------------------------------------------------------------------------
// oubl_pkg
// Shared codes, controller states and control/status bundles of the
// ordered unique byte list.
// ---------------------------------------------------------------------------
package oubl_pkg;

  localparam int CAPACITY_DEFAULT = 64;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_APPEND = 3'd1;
  localparam logic [2:0] CMD_INSERT = 3'd2;
  localparam logic [2:0] CMD_MODIFY = 3'd3;
  localparam logic [2:0] CMD_DUMP   = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ASCAN_RD,
    S_ASCAN_CHK,
    S_DSCAN_RD,
    S_DSCAN_CHK,
    S_DEL_RD,
    S_DEL_WR,
    S_INS_RD,
    S_INS_WR,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_NEXT,
    RD_IDX_PREV
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_IDX_RD,
    WR_TAIL_KEY,
    WR_POS_KEY
  } wr_op_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC,
    IDX_COUNT
  } idx_op_t;

  typedef struct packed {
    logic       load_in;
    logic       clear_count;
    logic       count_inc;
    logic       count_dec;
    logic       key_load_new;
    logic       scan_step;
    logic       rd_en;
    rd_sel_t    rd_sel;
    wr_op_t     wr_op;
    idx_op_t    idx_op;
    logic       pos_ins;
    logic       set_status;
    logic [1:0] status_code;
    logic       out_load_item;
    logic       out_load_result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       scan_end;
    logic       match;
    logic       del_end;
    logic       ins_end;
    logic       full;
    logic       count_zero;
    logic       dump_last;
    logic       out_free;
  } dp_status_t;

endpackage

// File: hdl/oubl_datapath.sv
// ---------------------------------------------------------------------------
// oubl_datapath
// Entry memory, walking index, count, key registers and result register.
// ---------------------------------------------------------------------------
module oubl_datapath #(
  parameter int CAPACITY = oubl_pkg::CAPACITY_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  oubl_pkg::ctrl_cmd_t   c,
  output oubl_pkg::dp_status_t  s,
  input  logic [2:0]            cmd,
  input  logic signed [7:0]     value,
  input  logic signed [7:0]     new_value,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic signed [7:0]     item,
  output logic                  item_valid,
  output logic [1:0]            status,
  output logic                  last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [7:0]    mem [CAPACITY];
  logic [7:0]    rd_data;
  logic [7:0]    key;
  logic [7:0]    new_key;
  logic [2:0]    cmd_q;
  logic [1:0]    res_status;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic [CW-1:0] ins_pos;
  logic          gt_seen;

  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_dec;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          wr_en;
  logic          greater;

  assign idx_inc = idx + 1'b1;
  assign idx_dec = idx - 1'b1;
  assign greater = $signed(rd_data) > $signed(key);

  always_comb begin
    case (c.rd_sel)
      oubl_pkg::RD_IDX:      rd_addr = idx[AW-1:0];
      oubl_pkg::RD_IDX_NEXT: rd_addr = idx_inc[AW-1:0];
      oubl_pkg::RD_IDX_PREV: rd_addr = idx_dec[AW-1:0];
      default:               rd_addr = idx[AW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx[AW-1:0];
    wr_data = rd_data;
    case (c.wr_op)
      oubl_pkg::WR_IDX_RD: begin
        wr_addr = idx[AW-1:0];
        wr_data = rd_data;
      end
      oubl_pkg::WR_TAIL_KEY: begin
        wr_addr = count[AW-1:0];
        wr_data = key;
      end
      oubl_pkg::WR_POS_KEY: begin
        wr_addr = pos[AW-1:0];
        wr_data = key;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (c.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (c.clear_count) begin
      count <= '0;
    end else if (c.count_inc) begin
      count <= count + 1'b1;
    end else if (c.count_dec) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (c.load_in) begin
      cmd_q   <= cmd;
      key     <= value;
      new_key <= new_value;
    end else if (c.key_load_new) begin
      key <= new_key;
    end

    // first entry greater than the key is the sorted insert position
    if (c.load_in || c.key_load_new) begin
      gt_seen <= 1'b0;
    end else if (c.scan_step && !gt_seen && greater) begin
      gt_seen <= 1'b1;
      ins_pos <= idx;
    end

    if (c.pos_ins) begin
      pos <= gt_seen ? ins_pos : count;
    end

    if (c.load_in) begin
      res_status <= oubl_pkg::ST_DONE;
    end else if (c.set_status) begin
      res_status <= c.status_code;
    end

    case (c.idx_op)
      oubl_pkg::IDX_ZERO:  idx <= '0;
      oubl_pkg::IDX_INC:   idx <= idx_inc;
      oubl_pkg::IDX_DEC:   idx <= idx_dec;
      oubl_pkg::IDX_COUNT: idx <= count;
      default:             idx <= idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c.out_load_item || c.out_load_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c.out_load_item) begin
      item       <= rd_data;
      item_valid <= 1'b1;
      status     <= oubl_pkg::ST_DONE;
      last       <= (idx_inc == count);
    end else if (c.out_load_result) begin
      item       <= '0;
      item_valid <= 1'b0;
      status     <= res_status;
      last       <= 1'b1;
    end
  end

  always_comb begin
    s.cmd        = cmd_q;
    s.scan_end   = (idx == count);
    s.match      = (rd_data == key);
    s.del_end    = (idx_inc >= count);
    s.ins_end    = (idx == pos);
    s.full       = (count >= CW'(CAPACITY));
    s.count_zero = (count == '0);
    s.dump_last  = (idx_inc == count);
    s.out_free   = !out_valid || !out_stall;
  end

endmodule

// File: hdl/oubl_ctrl.sv
// ---------------------------------------------------------------------------
// oubl_ctrl
// Sequencer for scan, shift-delete, shift-insert, dump and result delivery.
// ---------------------------------------------------------------------------
module oubl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  oubl_pkg::dp_status_t  s,
  output oubl_pkg::ctrl_cmd_t   c
);

  oubl_pkg::state_t state;
  oubl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oubl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      oubl_pkg::S_IDLE: begin
        if (in_valid) state_next = oubl_pkg::S_DISPATCH;
      end
      oubl_pkg::S_DISPATCH: begin
        case (s.cmd)
          oubl_pkg::CMD_APPEND: state_next = oubl_pkg::S_ASCAN_RD;
          oubl_pkg::CMD_INSERT: state_next = oubl_pkg::S_ASCAN_RD;
          oubl_pkg::CMD_MODIFY: state_next = oubl_pkg::S_DSCAN_RD;
          oubl_pkg::CMD_DUMP: begin
            state_next = s.count_zero ? oubl_pkg::S_RESULT : oubl_pkg::S_DUMP_RD;
          end
          default: state_next = oubl_pkg::S_RESULT;
        endcase
      end
      oubl_pkg::S_ASCAN_RD: begin
        if (!s.scan_end) begin
          state_next = oubl_pkg::S_ASCAN_CHK;
        end else if (s.full || s.cmd == oubl_pkg::CMD_APPEND) begin
          state_next = oubl_pkg::S_RESULT;
        end else begin
          state_next = oubl_pkg::S_INS_RD;
        end
      end
      oubl_pkg::S_ASCAN_CHK: begin
        state_next = s.match ? oubl_pkg::S_RESULT : oubl_pkg::S_ASCAN_RD;
      end
      oubl_pkg::S_DSCAN_RD: begin
        state_next = s.scan_end ? oubl_pkg::S_RESULT : oubl_pkg::S_DSCAN_CHK;
      end
      oubl_pkg::S_DSCAN_CHK: begin
        state_next = s.match ? oubl_pkg::S_DEL_RD : oubl_pkg::S_DSCAN_RD;
      end
      oubl_pkg::S_DEL_RD: begin
        state_next = s.del_end ? oubl_pkg::S_ASCAN_RD : oubl_pkg::S_DEL_WR;
      end
      oubl_pkg::S_DEL_WR: state_next = oubl_pkg::S_DEL_RD;
      oubl_pkg::S_INS_RD: begin
        state_next = s.ins_end ? oubl_pkg::S_RESULT : oubl_pkg::S_INS_WR;
      end
      oubl_pkg::S_INS_WR:  state_next = oubl_pkg::S_INS_RD;
      oubl_pkg::S_DUMP_RD: state_next = oubl_pkg::S_DUMP_OUT;
      oubl_pkg::S_DUMP_OUT: begin
        if (s.out_free) begin
          state_next = s.dump_last ? oubl_pkg::S_IDLE : oubl_pkg::S_DUMP_RD;
        end
      end
      oubl_pkg::S_RESULT: begin
        if (s.out_free) state_next = oubl_pkg::S_IDLE;
      end
      default: state_next = oubl_pkg::S_IDLE;
    endcase
  end

  assign in_stall = rst || (state != oubl_pkg::S_IDLE);

  always_comb begin
    c = '0;
    case (state)
      oubl_pkg::S_IDLE: begin
        if (in_valid) begin
          c.load_in = 1'b1;
          c.idx_op  = oubl_pkg::IDX_ZERO;
        end
      end
      oubl_pkg::S_DISPATCH: begin
        if (s.cmd == oubl_pkg::CMD_CLEAR) c.clear_count = 1'b1;
      end
      oubl_pkg::S_ASCAN_RD: begin
        if (!s.scan_end) begin
          c.rd_en  = 1'b1;
          c.rd_sel = oubl_pkg::RD_IDX;
        end else if (s.full) begin
          c.set_status  = 1'b1;
          c.status_code = oubl_pkg::ST_FULL;
        end else if (s.cmd == oubl_pkg::CMD_APPEND) begin
          c.wr_op     = oubl_pkg::WR_TAIL_KEY;
          c.count_inc = 1'b1;
        end else begin
          c.pos_ins = 1'b1;
          c.idx_op  = oubl_pkg::IDX_COUNT;
        end
      end
      oubl_pkg::S_ASCAN_CHK: begin
        if (s.match) begin
          c.set_status  = 1'b1;
          c.status_code = oubl_pkg::ST_DUP;
        end else begin
          c.scan_step = 1'b1;
          c.idx_op    = oubl_pkg::IDX_INC;
        end
      end
      oubl_pkg::S_DSCAN_RD: begin
        if (s.scan_end) begin
          c.set_status  = 1'b1;
          c.status_code = oubl_pkg::ST_MISSING;
        end else begin
          c.rd_en  = 1'b1;
          c.rd_sel = oubl_pkg::RD_IDX;
        end
      end
      oubl_pkg::S_DSCAN_CHK: begin
        // on a hit the index stays at the entry to delete
        if (!s.match) c.idx_op = oubl_pkg::IDX_INC;
      end
      oubl_pkg::S_DEL_RD: begin
        if (s.del_end) begin
          c.count_dec    = 1'b1;
          c.key_load_new = 1'b1;
          c.idx_op       = oubl_pkg::IDX_ZERO;
        end else begin
          c.rd_en  = 1'b1;
          c.rd_sel = oubl_pkg::RD_IDX_NEXT;
        end
      end
      oubl_pkg::S_DEL_WR: begin
        c.wr_op  = oubl_pkg::WR_IDX_RD;
        c.idx_op = oubl_pkg::IDX_INC;
      end
      oubl_pkg::S_INS_RD: begin
        if (s.ins_end) begin
          c.wr_op     = oubl_pkg::WR_POS_KEY;
          c.count_inc = 1'b1;
        end else begin
          c.rd_en  = 1'b1;
          c.rd_sel = oubl_pkg::RD_IDX_PREV;
        end
      end
      oubl_pkg::S_INS_WR: begin
        c.wr_op  = oubl_pkg::WR_IDX_RD;
        c.idx_op = oubl_pkg::IDX_DEC;
      end
      oubl_pkg::S_DUMP_RD: begin
        c.rd_en  = 1'b1;
        c.rd_sel = oubl_pkg::RD_IDX;
      end
      oubl_pkg::S_DUMP_OUT: begin
        if (s.out_free) begin
          c.out_load_item = 1'b1;
          c.idx_op        = oubl_pkg::IDX_INC;
        end
      end
      oubl_pkg::S_RESULT: begin
        if (s.out_free) c.out_load_result = 1'b1;
      end
      default: begin
        c = '0;
      end
    endcase
  end

endmodule

// File: hdl/ordered_unique_byte_list_top.sv
// ---------------------------------------------------------------------------
// ordered_unique_byte_list_top
// Ordered list of distinct signed bytes with clear, append, sorted insert,
// modify and dump commands.
// ---------------------------------------------------------------------------
// Usage:
//   input channel  : in_valid / in_stall with cmd, value, new_value; one
//                    transaction carries one command
//   output channel : out_valid / out_stall with item, item_valid, status,
//                    last; last marks the final transaction of a command
//   one command is taken at a time; in_stall is high while it is worked on
//   clear, unused codes and dump of an empty list go straight to the
//   result; append scans for a duplicate, then writes the key at the tail;
//   sorted insert scans, then shifts entries up from the tail to the insert
//   position and writes the key; modify scans for the old value, shifts the
//   later entries down over it and inserts the new value in order; dump
//   reads and delivers the entries one after another; the single entry
//   memory reads each visited entry, then compares or writes it
//   the next command is accepted in the cycle after the last result is
//   loaded, while that result may still wait in the output register
//   out_stall holds the output register; a dump pauses on the pending entry
//   and resumes when it is taken
//   reset empties the list, drops any pending result and needs no sweep;
//   entries beyond the count are never read
// ---------------------------------------------------------------------------
module ordered_unique_byte_list_top #(
  parameter int CAPACITY = oubl_pkg::CAPACITY_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        cmd,
  input  logic signed [7:0] value,
  input  logic signed [7:0] new_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] item,
  output logic              item_valid,
  output logic [1:0]        status,
  output logic              last
);

  oubl_pkg::ctrl_cmd_t  ctrl_cmd;
  oubl_pkg::dp_status_t dp_status;

  oubl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .s        (dp_status),
    .c        (ctrl_cmd)
  );

  oubl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .c          (ctrl_cmd),
    .s          (dp_status),
    .cmd        (cmd),
    .value      (value),
    .new_value  (new_value),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .item       (item),
    .item_valid (item_valid),
    .status     (status),
    .last       (last)
  );

endmodule

// File: hdl/oubl_checker.sv
// ---------------------------------------------------------------------------
// oubl_checker
// Port-level checks of the ordered unique byte list, bound to the top level.
// ---------------------------------------------------------------------------
`include "ordered_unique_byte_list_top_assert.svh"

module oubl_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [7:0] item,
  input logic              item_valid,
  input logic [1:0]        status,
  input logic              last
);

  // a stalled output transaction stays put
  `OUBL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(item) && $stable(item_valid) && $stable(status) && $stable(last), "output changed while stalled")

  // dumped entries always carry the done status
  `OUBL_ASSERT(a_item_status, out_valid && item_valid |-> status == oubl_pkg::ST_DONE, "dump entry with non-done status")

  // a command result has a zero item and closes its command
  `OUBL_ASSERT(a_result_shape, out_valid && !item_valid |-> item == 8'sd0 && last, "malformed command result")

  // reset drops any pending result
  `OUBL_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid after reset")

endmodule

bind ordered_unique_byte_list_top oubl_checker u_oubl_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .item       (item),
  .item_valid (item_valid),
  .status     (status),
  .last       (last)
);

// File: verif/ordered_unique_byte_list_top_test.sv
// ---------------------------------------------------------------------------
// ordered_unique_byte_list_top_test
// Self-checking bench for the ordered unique byte list. A directed command
// table runs first, then random bursts and list fill sequences. Every
// transaction on the output channel is compared with a queue of expected results
// from a behavioral model of the list or the directed table, under several sender and receiver idle mixes.
// ---------------------------------------------------------------------------
module ordered_unique_byte_list_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_CAP     = oubl_pkg::CAPACITY_DEFAULT;
  localparam int RANDOM_ITEMS = 445;
  localparam int PHASE_ITEMS  = 60;
  localparam int SETTLE_CYCLES = 6 * LIST_CAP + 16;

  // command codes the block does not decode
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  typedef struct packed {
    logic signed [7:0] item;
    logic              item_valid;
    logic [1:0]        status;
    logic              last;
  } list_result_t;

  typedef struct packed {
    logic [2:0]        op;
    logic signed [7:0] val;
    logic signed [7:0] nval;
    logic              typed;
    logic [1:0]        st;
  } cmd_row_t;

  localparam int DIR_ROWS = 25;

  // typed rows carry an expected status; the others go through the list model
  cmd_row_t cmd_table [DIR_ROWS] = '{
    '{oubl_pkg::CMD_DUMP,   8'sd0,   8'sd0,   1'b1, oubl_pkg::ST_DONE},
    '{oubl_pkg::CMD_MODIFY, 8'sd5,   8'sd6,   1'b1, oubl_pkg::ST_MISSING},
    '{oubl_pkg::CMD_APPEND, 8'sd127, 8'sd0,   1'b1, oubl_pkg::ST_DONE},
    '{oubl_pkg::CMD_APPEND, 8'sh80,  8'sd0,   1'b1, oubl_pkg::ST_DONE},
    '{oubl_pkg::CMD_APPEND, 8'sd127, 8'sd0,   1'b1, oubl_pkg::ST_DUP},
    '{oubl_pkg::CMD_INSERT, 8'sd0,   8'sd0,   1'b0, oubl_pkg::ST_DONE},
    '{oubl_pkg::CMD_INSERT, 8'sh80,  8'sd0,   1'b1, oubl_pkg::ST_DUP},
    '{oubl_pkg::CMD_INSERT, 8'sd5,   8'sh7F,  1'b0, oubl_pkg::ST_DONE},
    '{oubl_pkg::CMD_DUMP,   8'sd0,   8'sd0,   1'b0, oubl_pkg::ST_DONE},
    '{oubl_pkg::CMD_MODIFY, 8'sd0,   8'sd0,   1'b1, oubl_pkg::ST_DONE},
    '{oubl_pkg::CMD_MODIFY, 8'sd127, 8'sh80,  1'b1, oubl_pkg::ST_DUP},
    '{oubl_pkg::CMD_MODIFY, 8'shFF,  8'sd3,   1'b1, oubl_pkg::ST_MISSING},
    '{oubl_pkg::CMD_MODIFY, 8'sd5,   8'shF9,  1'b0, oubl_pkg::ST_DONE},
    '{oubl_pkg::CMD_DUMP,   8'sd0,   8'sd0,   1'b0, oubl_pkg::ST_DONE},
    '{CMD_SPARE_A,          8'sh55,  8'shAA,  1'b1, oubl_pkg::ST_DONE},
    '{CMD_SPARE_B,          8'shAA,  8'sh55,  1'b1, oubl_pkg::ST_DONE},
    '{CMD_SPARE_C,          8'shFF,  8'shFF,  1'b1, oubl_pkg::ST_DONE},
    '{oubl_pkg::CMD_INSERT, 8'shFF,  8'sd0,   1'b0, oubl_pkg::ST_DONE},
    '{oubl_pkg::CMD_APPEND, 8'shFE,  8'sd0,   1'b0, oubl_pkg::ST_DONE},
    '{oubl_pkg::CMD_DUMP,   8'sd0,   8'sd0,   1'b0, oubl_pkg::ST_DONE},
    '{oubl_pkg::CMD_CLEAR,  8'sd9,   8'sd9,   1'b1, oubl_pkg::ST_DONE},
    '{oubl_pkg::CMD_DUMP,   8'sd0,   8'sd0,   1'b1, oubl_pkg::ST_DONE},
    '{oubl_pkg::CMD_INSERT, 8'sh80,  8'sd0,   1'b1, oubl_pkg::ST_DONE},
    '{oubl_pkg::CMD_INSERT, 8'sd127, 8'sd0,   1'b1, oubl_pkg::ST_DONE},
    '{oubl_pkg::CMD_DUMP,   8'sd0,   8'sd0,   1'b0, oubl_pkg::ST_DONE}
  };

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        cmd;
  logic signed [7:0] value;
  logic signed [7:0] new_value;
  logic              out_valid;
  logic              out_stall;
  logic signed [7:0] item;
  logic              item_valid;
  logic [1:0]        status;
  logic              last;

  logic signed [7:0] list_q [$];
  list_result_t      pending_results [$];
  int                err_count;
  int                sent_count;
  int                send_idle_pct;
  int                recv_stall_pct;

  ordered_unique_byte_list_top #(
    .CAPACITY(LIST_CAP)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .value     (value),
    .new_value (new_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .item      (item),
    .item_valid(item_valid),
    .status    (status),
    .last      (last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #15_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---- list model ----------------------------------------------------------

  function automatic void expect_result(list_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic int list_find(logic signed [7:0] v);
    foreach (list_q[i]) begin
      if (list_q[i] == v) return i;
    end
    return -1;
  endfunction

  function automatic logic [1:0] list_append(logic signed [7:0] v);
    if (list_find(v) >= 0) return oubl_pkg::ST_DUP;
    if (list_q.size() >= LIST_CAP) return oubl_pkg::ST_FULL;
    list_q.insert(list_q.size(), v);
    return oubl_pkg::ST_DONE;
  endfunction

  function automatic logic [1:0] list_insert(logic signed [7:0] v);
    int pos;
    if (list_find(v) >= 0) return oubl_pkg::ST_DUP;
    if (list_q.size() >= LIST_CAP) return oubl_pkg::ST_FULL;
    pos = 0;
    while (pos < list_q.size() && list_q[pos] <= v) pos++;
    list_q.insert(pos, v);
    return oubl_pkg::ST_DONE;
  endfunction

  // updates the list and, when keep is set, queues the results it produces
  function automatic void list_apply(logic [2:0] op, logic signed [7:0] v,
                                     logic signed [7:0] nv, bit keep);
    logic [1:0]   st;
    int           idx;
    list_result_t r;
    st = oubl_pkg::ST_DONE;
    if (op == oubl_pkg::CMD_DUMP && list_q.size() > 0) begin
      foreach (list_q[i]) begin
        r.item       = list_q[i];
        r.item_valid = 1'b1;
        r.status     = oubl_pkg::ST_DONE;
        r.last       = (i == list_q.size() - 1);
        if (keep) expect_result(r);
      end
      return;
    end
    case (op)
      oubl_pkg::CMD_CLEAR:  list_q.delete();
      oubl_pkg::CMD_APPEND: st = list_append(v);
      oubl_pkg::CMD_INSERT: st = list_insert(v);
      oubl_pkg::CMD_MODIFY: begin
        idx = list_find(v);
        if (idx < 0) begin
          st = oubl_pkg::ST_MISSING;
        end else begin
          list_q.delete(idx);
          st = list_insert(nv);
        end
      end
      default: st = oubl_pkg::ST_DONE;
    endcase
    r = '{item: 8'sd0, item_valid: 1'b0, status: st, last: 1'b1};
    if (keep) expect_result(r);
  endfunction

  // ---- stimulus helpers ----------------------------------------------------

  function automatic logic signed [7:0] rand_byte();
    logic signed [7:0] b;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: b = 8'sh80;
          1: b = 8'sh7F;
          2: b = 8'sd0;
          default: b = 8'shFF;
        endcase
      end
      1, 2, 3: begin
        // narrow pool so duplicates and modify hits are common
        b = 8'($urandom_range(0, 15));
        b = b - 8'sd8;
      end
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  function automatic logic signed [7:0] pick_present();
    if (list_q.size() == 0) return rand_byte();
    return list_q[$urandom_range(0, list_q.size() - 1)];
  endfunction

  function automatic logic signed [7:0] pick_absent();
    logic signed [7:0] b;
    do b = 8'($urandom); while (list_find(b) >= 0);
    return b;
  endfunction

  // one input transaction; returns just after the accepting edge
  task automatic send(logic [2:0] op, logic signed [7:0] v, logic signed [7:0] nv,
                      bit typed = 1'b0, logic [1:0] typed_st = oubl_pkg::ST_DONE);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    value     <= v;
    new_value <= nv;
    do @(posedge clk); while (in_stall);
    list_apply(op, v, nv, !typed);
    if (typed) begin
      expect_result('{item: 8'sd0, item_valid: 1'b0, status: typed_st, last: 1'b1});
    end
    sent_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // fill to capacity, then hit the full and duplicate-while-full cases, dump, modify and sometimes clear
  task automatic fill_list();
    while (list_q.size() < LIST_CAP) begin
      send($urandom_range(0, 1) ? oubl_pkg::CMD_APPEND : oubl_pkg::CMD_INSERT,
           rand_byte(), rand_byte());
    end
    send(oubl_pkg::CMD_INSERT, pick_absent(), rand_byte());
    send(oubl_pkg::CMD_APPEND, pick_absent(), rand_byte());
    send(oubl_pkg::CMD_APPEND, pick_present(), rand_byte());
    send(oubl_pkg::CMD_INSERT, pick_present(), rand_byte());
    send(oubl_pkg::CMD_DUMP, rand_byte(), rand_byte());
    send(oubl_pkg::CMD_MODIFY, pick_present(), pick_absent());
    if ($urandom_range(0, 1)) send(oubl_pkg::CMD_CLEAR, rand_byte(), rand_byte());
  endtask

  task automatic random_burst();
    int                n;
    int                w;
    logic signed [7:0] v;
    n = $urandom_range(1, 6);
    repeat (n) begin
      w = $urandom_range(0, 99);
      v = rand_byte();
      if (w < 20) send(oubl_pkg::CMD_APPEND, v, rand_byte());
      else if (w < 45) send(oubl_pkg::CMD_INSERT, v, rand_byte());
      else if (w < 60) send(oubl_pkg::CMD_MODIFY, pick_present(), v);
      else if (w < 66) send(oubl_pkg::CMD_MODIFY, pick_present(), pick_present());
      else if (w < 70) begin
        v = pick_present();
        send(oubl_pkg::CMD_MODIFY, v, v);
      end
      else if (w < 78) send(oubl_pkg::CMD_MODIFY, v, rand_byte());
      else if (w < 92) send(oubl_pkg::CMD_DUMP, v, rand_byte());
      else if (w < 96) send(3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C)), v, rand_byte());
      else send(oubl_pkg::CMD_CLEAR, v, rand_byte());
    end
  endtask

  // ---- receiver and checker ------------------------------------------------

  always @(negedge clk) begin
    if (!rst) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    list_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected transaction, expected none actual item %0h status %0d",
                 $time, item, status);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("item", exp_r.item, item);
        check_field("item_valid", 8'(exp_r.item_valid), 8'(item_valid));
        check_field("status", 8'(exp_r.status), 8'(status));
        check_field("last", 8'(exp_r.last), 8'(last));
      end
    end
  end

  // ---- main sequence -------------------------------------------------------

  initial begin
    int phase;
    int cur_phase;
    int r;
    bit filled_once;
    rst            = 1'b1;
    in_valid       = 1'b0;
    cmd            = oubl_pkg::CMD_CLEAR;
    value          = 8'sd0;
    new_value      = 8'sd0;
    out_stall      = 1'b0;
    err_count      = 0;
    sent_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_phase      = -1;
    filled_once    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (cmd_table[i]) begin
      send(cmd_table[i].op, cmd_table[i].val, cmd_table[i].nval,
           cmd_table[i].typed, cmd_table[i].st);
    end

    while (sent_count < DIR_ROWS + RANDOM_ITEMS) begin
      phase = ((sent_count - DIR_ROWS) / PHASE_ITEMS) % 5;
      if (phase != cur_phase) begin
        // let the block run dry before the idle mix changes
        wait_drained();
        cur_phase = phase;
        case (phase)
          1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
          2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
          3:       begin send_idle_pct = 12; recv_stall_pct = 12; end
          default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
      end
      r = $urandom_range(0, 99);
      if (!filled_once || r < 3) begin
        fill_list();
        filled_once = 1'b1;
      end else if (r < 7) begin
        send(oubl_pkg::CMD_CLEAR, rand_byte(), rand_byte());
      end else begin
        random_burst();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/oubl_pkg.sv
hdl/oubl_datapath.sv
hdl/oubl_ctrl.sv
hdl/ordered_unique_byte_list_top.sv
hdl/oubl_checker.sv
verif/ordered_unique_byte_list_top_test.sv
